>>> design/mpm_pkg.sv
// Package: shared constants, controller states, command and status types.
`default_nettype none
package mpm_pkg;

  localparam int unsigned ENTRY_WIDTH_DEF = 16;
  localparam int unsigned EXP_WIDTH_DEF   = 31;

  localparam logic [1:0] LAST_ENTRY = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FIND,
    ST_NEXT,
    ST_MULA,
    ST_MULB,
    ST_RED,
    ST_STORE,
    ST_DONE
  } mpm_state_e;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_SQR,
    OP_MUL
  } mpm_op_e;

  typedef struct packed {
    logic    load_in;
    logic    shift_exp;
    mpm_op_e op;
    logic    mul_a;
    logic    mul_b;
    logic    red_step;
    logic    store;
    logic [1:0] k;
    logic    out_load;
  } mpm_cmd_t;

  typedef struct packed {
    logic exp_msb;
    logic exp_zero;
    logic mod_zero;
  } mpm_sts_t;

endpackage
`default_nettype wire

>>> design/mpm_datapath.sv
// Datapath: matrix registers, entry multiply-accumulate, bit-serial remainder.
`default_nettype none
module mpm_datapath #(
  parameter int unsigned EW = mpm_pkg::ENTRY_WIDTH_DEF,
  parameter int unsigned XW = mpm_pkg::EXP_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire mpm_pkg::mpm_cmd_t   cmd_i,
  output mpm_pkg::mpm_sts_t        sts_o,
  input  wire logic [EW-1:0]       a00_i,
  input  wire logic [EW-1:0]       a01_i,
  input  wire logic [EW-1:0]       a10_i,
  input  wire logic [EW-1:0]       a11_i,
  input  wire logic [XW-1:0]       exponent_i,
  input  wire logic [EW-1:0]       modulus_i,
  output logic [EW-1:0]            r00_o,
  output logic [EW-1:0]            r01_o,
  output logic [EW-1:0]            r10_o,
  output logic [EW-1:0]            r11_o
);
  import mpm_pkg::*;

  localparam int unsigned SW = 2 * EW + 1;

  logic [EW-1:0] base_q [4];
  logic [EW-1:0] acc_q  [4];
  logic [EW-1:0] t_q    [4];
  logic [XW-1:0] exp_q;
  logic [EW-1:0] mod_q;
  logic          ez_q, mz_q;
  logic [SW-1:0] s_q;
  logic [EW-1:0] r_q;
  logic [EW-1:0] out_q [4];

  logic [EW-1:0]   x0, x1, y0, y1;
  logic [2*EW-1:0] p0, p1;
  logic [EW:0]     rem_t;
  logic [EW-1:0]   rem_n;

  always_comb begin
    if (cmd_i.op == OP_SQR) begin
      x0 = acc_q[{cmd_i.k[1], 1'b0}];
      x1 = acc_q[{cmd_i.k[1], 1'b1}];
    end else begin
      x0 = base_q[{cmd_i.k[1], 1'b0}];
      x1 = base_q[{cmd_i.k[1], 1'b1}];
    end
    y0 = acc_q[{1'b0, cmd_i.k[0]}];
    y1 = acc_q[{1'b1, cmd_i.k[0]}];
    p0 = x0 * y0;
    p1 = x1 * y1;
    // one remainder step: shift in the next dividend bit, subtract if it fits
    rem_t = {r_q, s_q[SW-1]};
    if (rem_t >= {1'b0, mod_q}) begin
      rem_t = rem_t - {1'b0, mod_q};
    end
    rem_n = rem_t[EW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      base_q[0] <= a00_i;
      base_q[1] <= a01_i;
      base_q[2] <= a10_i;
      base_q[3] <= a11_i;
      exp_q     <= exponent_i;
      mod_q     <= modulus_i;
      ez_q      <= (exponent_i == '0);
      mz_q      <= (modulus_i == '0);
    end else if (cmd_i.shift_exp) begin
      exp_q <= exp_q << 1;
    end
    if (cmd_i.mul_a) begin
      r_q <= '0;
      if (cmd_i.op == OP_INIT) begin
        s_q <= {{(SW-EW){1'b0}}, base_q[cmd_i.k]};
      end else begin
        s_q <= {1'b0, p0};
      end
    end else if (cmd_i.mul_b) begin
      s_q <= s_q + {1'b0, p1};
    end else if (cmd_i.red_step) begin
      s_q <= s_q << 1;
      r_q <= rem_n;
    end
    if (cmd_i.store) begin
      t_q[cmd_i.k] <= r_q;
      if (cmd_i.k == LAST_ENTRY) begin
        acc_q[0] <= t_q[0];
        acc_q[1] <= t_q[1];
        acc_q[2] <= t_q[2];
        acc_q[3] <= r_q;
      end
    end
    if (cmd_i.out_load) begin
      if (ez_q) begin
        out_q[0] <= EW'(1);
        out_q[1] <= '0;
        out_q[2] <= '0;
        out_q[3] <= EW'(1);
      end else if (mz_q) begin
        out_q[0] <= '0;
        out_q[1] <= '0;
        out_q[2] <= '0;
        out_q[3] <= '0;
      end else begin
        out_q <= acc_q;
      end
    end
  end

  assign sts_o.exp_msb  = exp_q[XW-1];
  assign sts_o.exp_zero = ez_q;
  assign sts_o.mod_zero = mz_q;

  assign r00_o = out_q[0];
  assign r01_o = out_q[1];
  assign r10_o = out_q[2];
  assign r11_o = out_q[3];

endmodule
`default_nettype wire

>>> design/mpm_ctrl.sv
// Controller: sequences exponent scan, entry products and remainder steps.
`default_nettype none
module mpm_ctrl #(
  parameter int unsigned EW = mpm_pkg::ENTRY_WIDTH_DEF,
  parameter int unsigned XW = mpm_pkg::EXP_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mpm_pkg::mpm_cmd_t       cmd_o,
  input  wire mpm_pkg::mpm_sts_t  sts_i
);
  import mpm_pkg::*;

  localparam int unsigned SW = 2 * EW + 1;
  localparam int unsigned RW = $clog2(SW);
  localparam int unsigned BW = (XW > 1) ? $clog2(XW) : 1;

  mpm_state_e    state_q, state_d;
  mpm_op_e       op_q, op_d;
  logic [1:0]    k_q, k_d;
  logic [BW-1:0] bit_q, bit_d;
  logic [RW-1:0] red_q, red_d;
  logic          out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_INIT;
      k_q         <= '0;
      bit_q       <= '0;
      red_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      k_q         <= k_d;
      bit_q       <= bit_d;
      red_q       <= red_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    k_d         = k_q;
    bit_d       = bit_q;
    red_d       = red_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o       = '0;
    cmd_o.op    = op_q;
    cmd_o.k     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.exp_zero || sts_i.mod_zero) begin
          state_d = ST_DONE;
        end else begin
          bit_d   = BW'(XW - 1);
          state_d = ST_FIND;
        end
      end
      ST_FIND: begin
        if (sts_i.exp_msb) begin
          op_d    = OP_INIT;
          k_d     = '0;
          state_d = ST_MULA;
        end else begin
          cmd_o.shift_exp = 1'b1;
          bit_d           = bit_q - 1'b1;
        end
      end
      ST_NEXT: begin
        if (bit_q == '0) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.shift_exp = 1'b1;
          bit_d           = bit_q - 1'b1;
          op_d            = OP_SQR;
          k_d             = '0;
          state_d         = ST_MULA;
        end
      end
      ST_MULA: begin
        cmd_o.mul_a = 1'b1;
        red_d       = RW'(SW - 1);
        state_d     = (op_q == OP_INIT) ? ST_RED : ST_MULB;
      end
      ST_MULB: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_RED;
      end
      ST_RED: begin
        cmd_o.red_step = 1'b1;
        if (red_q == '0) begin
          state_d = ST_STORE;
        end else begin
          red_d = red_q - 1'b1;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        if (k_q != LAST_ENTRY) begin
          k_d     = k_q + 1'b1;
          state_d = ST_MULA;
        end else begin
          k_d = '0;
          if (op_q == OP_SQR && sts_i.exp_msb) begin
            op_d    = OP_MUL;
            state_d = ST_MULA;
          end else begin
            state_d = ST_NEXT;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

>>> design/matrix_power_2x2_mod_top.sv
// Top level: modular 2x2 matrix power, controller plus datapath.
`default_nettype none
// Each 2x2 modular product forms its four entries in turn through the one-bit-per-cycle
// remainder unit shared by all four entries. Per request: scan to the exponent's leading one,
// reduce the base, then square once per further bit and multiply after each one bit.
// Exponent or modulus zero skips the products. One request is in flight at a time.
// The result register holds a finished result while the next request is taken.
// Reset (async, active low) clears the controller only; no results pending after it.
module matrix_power_2x2_mod_top #(
  parameter int unsigned ENTRY_WIDTH = mpm_pkg::ENTRY_WIDTH_DEF,
  parameter int unsigned EXP_WIDTH   = mpm_pkg::EXP_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [ENTRY_WIDTH-1:0] a00_i,
  input  wire logic [ENTRY_WIDTH-1:0] a01_i,
  input  wire logic [ENTRY_WIDTH-1:0] a10_i,
  input  wire logic [ENTRY_WIDTH-1:0] a11_i,
  input  wire logic [EXP_WIDTH-1:0]   exponent_i,
  input  wire logic [ENTRY_WIDTH-1:0] modulus_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [ENTRY_WIDTH-1:0]      r00_o,
  output logic [ENTRY_WIDTH-1:0]      r01_o,
  output logic [ENTRY_WIDTH-1:0]      r10_o,
  output logic [ENTRY_WIDTH-1:0]      r11_o
);
  import mpm_pkg::*;

  // command and status between controller and datapath
  mpm_cmd_t cmd;
  mpm_sts_t sts;

  mpm_ctrl #(
    .EW (ENTRY_WIDTH),
    .XW (EXP_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // matrices, exponent shifter, multiply-accumulate and remainder unit
  mpm_datapath #(
    .EW (ENTRY_WIDTH),
    .XW (EXP_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .a00_i      (a00_i),
    .a01_i      (a01_i),
    .a10_i      (a10_i),
    .a11_i      (a11_i),
    .exponent_i (exponent_i),
    .modulus_i  (modulus_i),
    .r00_o      (r00_o),
    .r01_o      (r01_o),
    .r10_o      (r10_o),
    .r11_o      (r11_o)
  );

endmodule
`default_nettype wire
